FILE: design/gtg_pkg.sv
// Shared types and constants for the go-to-goal velocity controller.
// No dependencies.
package gtg_pkg;

  localparam int unsigned AngTabLen = 24;
  localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;
  localparam logic [15:0] InvKQ16 = 16'd39797;

  typedef enum logic [2:0] {
    REG_GOAL_X       = 3'd0,
    REG_GOAL_Y       = 3'd1,
    REG_LINEAR_GAIN  = 3'd2,
    REG_ANGULAR_GAIN = 3'd3,
    REG_STOP_RADIUS  = 3'd4
  } reg_idx_t;

  // CORDIC work word: dx, dy scaled by 2^12 plus growth
  typedef logic signed [31:0] cw_t;
  typedef logic signed [31:0] ang_t;

  // front-to-back queue entry
  typedef struct packed {
    logic [16:0]        distance;
    logic signed [15:0] bear;
    logic signed [14:0] heading;
    logic [7:0]         lin_gain;
    logic [7:0]         ang_gain;
    logic [14:0]        stop_radius;
  } job_t;

  function automatic ang_t atan_q28(input int unsigned i);
    case (i)
      0: atan_q28 = 32'sd210828714;
      1: atan_q28 = 32'sd124459457;
      2: atan_q28 = 32'sd65760959;
      3: atan_q28 = 32'sd33381290;
      4: atan_q28 = 32'sd16755422;
      5: atan_q28 = 32'sd8385879;
      6: atan_q28 = 32'sd4193963;
      7: atan_q28 = 32'sd2097109;
      8: atan_q28 = 32'sd1048571;
      9: atan_q28 = 32'sd524287;
      default: atan_q28 = 32'sd262144 >>> (i - 10);
    endcase
  endfunction

endpackage

FILE: design/gtg_front.sv
// Front part: pipelined vectoring CORDIC giving distance and bearing.
// Depends on gtg_pkg.
module gtg_front #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  pose_x,
  input  logic signed [15:0]  pose_y,
  input  logic signed [14:0]  heading,
  input  logic signed [15:0]  goal_x,
  input  logic signed [15:0]  goal_y,
  input  logic [7:0]          lin_gain,
  input  logic [7:0]          ang_gain,
  input  logic [14:0]         stop_radius,
  output logic                job_valid,
  input  logic                job_ready,
  output gtg_pkg::job_t       job
);
  import gtg_pkg::*;

  localparam int N = CORDIC_STAGES;
  // stage 0: pre-rotation, 1..N micro-rotations, N+1: scale multiply, N+2: round
  localparam int L = N + 3;

  logic [L-1:0] vld_r;
  cw_t          x_r [N+1];
  cw_t          y_r [N+1];
  ang_t         z_r [N+1];
  logic [L-1:0] zero_r;
  logic signed [14:0] hd_r [L];
  logic [7:0]   lg_r [L];
  logic [7:0]   ag_r [L];
  logic [14:0]  sr_r [L];
  logic [47:0]  prod_r;
  ang_t         zf_r;
  job_t         job_r;

  logic adv;
  assign adv      = !vld_r[L-1] || job_ready;
  assign in_ready = adv;
  assign job_valid = vld_r[L-1];
  assign job       = job_r;

  logic signed [16:0] dx, dy;
  cw_t x0, y0;
  ang_t z0;
  assign dx = 17'(goal_x) - 17'(pose_x);
  assign dy = 17'(goal_y) - 17'(pose_y);

  always_comb begin
    x0 = 32'(dx) <<< 12;
    y0 = 32'(dy) <<< 12;
    z0 = '0;
    if (dx < 0) begin
      if (dy >= 0) begin
        x0 = 32'(dy) <<< 12; y0 = -(32'(dx) <<< 12); z0 = HalfPiQ28;
      end else begin
        x0 = -(32'(dy) <<< 12); y0 = 32'(dx) <<< 12; z0 = -HalfPiQ28;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]  <= x0;
      y_r[0]  <= y0;
      z_r[0]  <= z0;
      zero_r[0] <= (dx == 0) && (dy == 0);
      hd_r[0] <= heading;
      lg_r[0] <= lin_gain;
      ag_r[0] <= ang_gain;
      sr_r[0] <= stop_radius;
      for (int i = 1; i < L; i++) begin
        zero_r[i] <= zero_r[i-1];
        hd_r[i] <= hd_r[i-1];
        lg_r[i] <= lg_r[i-1];
        ag_r[i] <= ag_r[i-1];
        sr_r[i] <= sr_r[i-1];
      end
      for (int i = 0; i < N; i++) begin
        if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q28(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q28(i);
        end
      end
      // clamp negative x, then scale by 1/K
      prod_r <= (x_r[N] < 0) ? '0 : 48'({16'b0, x_r[N]}) * 48'(InvKQ16);
      zf_r   <= z_r[N];
      job_r.distance <= zero_r[L-2] ? '0 : 17'((50'(prod_r) + 50'(1 << 27)) >> 28);
      job_r.bear <= zero_r[L-2] ? '0 : 16'((zf_r + 32'sd32768) >>> 16);
      job_r.heading     <= hd_r[L-2];
      job_r.lin_gain    <= lg_r[L-2];
      job_r.ang_gain    <= ag_r[L-2];
      job_r.stop_radius <= sr_r[L-2];
    end
  end
endmodule

FILE: design/gtg_queue.sv
// Two-entry queue between the front and back parts.
// Depends on gtg_pkg.
module gtg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  gtg_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output gtg_pkg::job_t rd_data
);
  import gtg_pkg::*;

  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

FILE: design/gtg_back.sv
// Back part: gains, saturation and the arrival result.
// Depends on gtg_pkg.
module gtg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  gtg_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_linear_speed,
  output logic signed [15:0] out_turn_rate,
  output logic               out_arrived,
  output logic               out_last
);
  import gtg_pkg::*;

  logic        pend_r;   // arrival item still owed
  logic        vld_r;
  logic [14:0] lin_r;
  logic signed [15:0] turn_r;
  logic        arr_r, last_r;

  logic [24:0] lin_p;
  logic signed [26:0] turn_p;
  logic signed [19:0] turn_s;
  logic [20:0] lin_s;
  logic take, load, arrive;

  assign lin_p  = 25'(job.lin_gain) * 25'(job.distance);
  assign lin_s  = 21'((lin_p + 25'd8) >> 4);
  assign turn_p = 27'($signed({1'b0, job.ang_gain})) *
                  (27'(job.bear) - 27'(job.heading));
  assign turn_s = 20'((turn_p + 27'sd64) >>> 7);
  assign arrive = {2'b0, job.distance} < {4'b0, job.stop_radius};

  assign load = !vld_r || out_ready;
  assign job_ready = load && !pend_r;
  assign take = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0; pend_r <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        vld_r <= 1'b1; pend_r <= 1'b0;
      end else begin
        vld_r <= take; pend_r <= take && arrive;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        lin_r <= '0; turn_r <= '0; arr_r <= 1'b1; last_r <= 1'b1;
      end else begin
        lin_r  <= (lin_s > 21'd32767) ? 15'd32767 : lin_s[14:0];
        turn_r <= (turn_s > 20'sd32767) ? 16'sh7fff :
                  (turn_s < -20'sd32768) ? 16'sh8000 : turn_s[15:0];
        arr_r  <= 1'b0;
        last_r <= !arrive;
      end
    end
  end

  assign out_valid = vld_r;
  assign out_linear_speed = lin_r;
  assign out_turn_rate = turn_r;
  assign out_arrived = arr_r;
  assign out_last = last_r;
endmodule

FILE: design/go_to_goal_velocity_controller.sv
// Top level of the go-to-goal velocity controller: registers, front, queue, back.
// Depends on gtg_pkg, gtg_front, gtg_queue, gtg_back.
//
//   channel | direction | payload
//   in_     | input     | pose_x, pose_y, heading
//   out_    | output    | linear_speed, turn_rate, arrived, last
//   cfg_    | input     | index (3 bits), data (16 bits)
//
// One pose per cycle while in_ready stays high; results pass the front pipeline, the queue and the back register.
// An arriving pose gives two results, so the back part takes no job while it
// gives the arrival item; the two-entry queue absorbs that.
// Synchronous active-low reset restores the register defaults.
// A stalled output, once the queue is full and a job waits at the end of the front, holds the whole CORDIC pipeline.
module go_to_goal_velocity_controller #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_pose_x,
  input  logic signed [15:0] in_pose_y,
  input  logic signed [14:0] in_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_linear_speed,
  output logic signed [15:0] out_turn_rate,
  output logic               out_arrived,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import gtg_pkg::*;

  logic signed [15:0] goal_x_r, goal_y_r;
  logic [7:0]  lin_gain_r, ang_gain_r;
  logic [14:0] stop_radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= 16'sd5632; goal_y_r <= 16'sd5632;
      lin_gain_r <= 8'd16; ang_gain_r <= 8'd64; stop_radius_r <= 15'd102;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GOAL_X:       goal_x_r <= cfg_data;
        REG_GOAL_Y:       goal_y_r <= cfg_data;
        REG_LINEAR_GAIN:  lin_gain_r <= cfg_data[7:0];
        REG_ANGULAR_GAIN: ang_gain_r <= cfg_data[7:0];
        REG_STOP_RADIUS:  stop_radius_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  gtg_front #(.CORDIC_STAGES(CORDIC_STAGES)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .pose_x(in_pose_x), .pose_y(in_pose_y), .heading(in_heading),
    .goal_x(goal_x_r), .goal_y(goal_y_r), .lin_gain(lin_gain_r),
    .ang_gain(ang_gain_r), .stop_radius(stop_radius_r),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  gtg_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
  );

  gtg_back u_back (
    .clk, .rst_n, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .out_valid, .out_ready, .out_linear_speed, .out_turn_rate,
    .out_arrived, .out_last
  );

  // an arrival item is always the last one of its pose
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_last && out_linear_speed == '0 && out_turn_rate == '0)
    else $error("arrival item not zero or not last");

  // a non-last item is always followed by its arrival item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_arrived)
    else $error("arrival item missing");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_turn_rate) && $stable(out_last))
    else $error("stalled result changed");

endmodule

FILE: dv/gtg_checker.sv
// Checker for the go-to-goal velocity controller: watches pose, result and register channels,
// predicts speed and turn commands and compares them. Depends on gtg_pkg.
`timescale 1ns / 100ps
module gtg_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_pose_x,
  input  logic signed [15:0] in_pose_y,
  input  logic signed [14:0] in_heading,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [14:0]        out_linear_speed,
  input  logic signed [15:0] out_turn_rate,
  input  logic               out_arrived,
  input  logic               out_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import gtg_pkg::*;

  typedef struct packed {
    logic [14:0]        speed;
    logic signed [15:0] turn;
    logic               arrived;
    logic               last;
  } cmd_t;

  cmd_t cmd_q[$];
  logic signed [15:0] goal_x, goal_y;
  logic [7:0]  lin_gain, ang_gain;
  logic [14:0] stop_radius;

  function automatic longint atan_step(int i);
    longint tab[24] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
                        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    return tab[i];
  endfunction

  task automatic predict_commands(logic signed [15:0] px, logic signed [15:0] py,
                                  logic signed [14:0] hd);
    longint dx, dy, x, y, z, t, xs, ys, dist_v, bear, lin, turn;
    cmd_t c;
    dx = longint'(goal_x) - px;
    dy = longint'(goal_y) - py;
    dist_v = 0;
    bear = 0;
    if (dx != 0 || dy != 0) begin
      x = dx * 4096;
      y = dy * 4096;
      z = 0;
      // pre-rotate a quarter turn when the goal lies behind
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 421657428;
        end else begin
          x = -y; y = t; z = -421657428;
        end
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y < 0) begin
          x -= ys; y += xs; z -= atan_step(i);
        end else begin
          x += ys; y -= xs; z += atan_step(i);
        end
      end
      if (x < 0) x = 0;
      dist_v = (x * 39797 + (64'sd1 <<< 27)) >>> 28;
      bear = (z + (64'sd1 <<< 15)) >>> 16;
    end
    lin = (longint'(lin_gain) * dist_v + 8) >>> 4;
    if (lin > 32767) lin = 32767;
    turn = (longint'(ang_gain) * (bear - hd) + 64) >>> 7;
    if (turn > 32767) turn = 32767;
    if (turn < -32768) turn = -32768;
    c.speed = lin[14:0];
    c.turn = turn[15:0];
    c.arrived = 1'b0;
    c.last = !(dist_v < longint'(stop_radius));
    cmd_q.push_back(c);
    if (!c.last) cmd_q.push_back('{15'd0, 16'sd0, 1'b1, 1'b1});
  endtask

  assign pending = cmd_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      goal_x <= 16'sd5632;
      goal_y <= 16'sd5632;
      lin_gain <= 8'd16;
      ang_gain <= 8'd64;
      stop_radius <= 15'd102;
      fail_count <= 0;
      cmd_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GOAL_X:       goal_x <= cfg_data;
          REG_GOAL_Y:       goal_y <= cfg_data;
          REG_LINEAR_GAIN:  lin_gain <= cfg_data[7:0];
          REG_ANGULAR_GAIN: ang_gain <= cfg_data[7:0];
          REG_STOP_RADIUS:  stop_radius <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result: speed %0d turn %0d",
                                        out_linear_speed, out_turn_rate);
          fail_count <= fail_count + 1;
        end else begin
          cmd_t e;
          e = cmd_q.pop_front();
          if (e != {out_linear_speed, out_turn_rate, out_arrived, out_last}) begin
            if (fail_count < 10)
              $display("mismatch: exp speed %0d turn %0d arr %0b last %0b, got %0d %0d %0b %0b",
                       e.speed, e.turn, e.arrived, e.last, out_linear_speed,
                       out_turn_rate, out_arrived, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_commands(in_pose_x, in_pose_y, in_heading);
    end
  end
endmodule

FILE: dv/tb_go_to_goal_velocity_controller.sv
// Testbench top for the go-to-goal velocity controller: poses, register writes, verdict.
// Depends on gtg_pkg, gtg_checker and the block itself.
`timescale 1ns / 100ps
module tb_go_to_goal_velocity_controller;
  import gtg_pkg::*;

  localparam int Latency = 20;
  localparam int StallLimit = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic signed [15:0] in_pose_x = '0, in_pose_y = '0;
  logic signed [14:0] in_heading = '0;
  logic out_valid, out_ready = 1'b0;
  logic [14:0] out_linear_speed;
  logic signed [15:0] out_turn_rate;
  logic out_arrived, out_last;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  go_to_goal_velocity_controller uut (.*);
  gtg_checker chk (.*);

  // result side: random stalls, none in the bursty phase
  logic steady_out = 1'b0;
  always begin
    int w;
    w = steady_out ? 0 : $urandom_range(0, 9);
    if (w != 0) begin
      out_ready <= 1'b0;
      repeat (w) @(posedge clk);
    end
    out_ready <= 1'b1;
    @(posedge clk);
    while (!out_valid) @(posedge clk);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit && rst_n) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // leaves valid high after acceptance; a gap or a drain drops it
  task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                           logic signed [14:0] hd, int gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pose_x <= px;
    in_pose_y <= py;
    in_heading <= hd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // leaves valid high after acceptance; the caller drops it
  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] gx, logic [15:0] gy, logic [7:0] lg,
                          logic [7:0] ag, logic [14:0] sr);
    wait_drained();
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_LINEAR_GAIN, lg);
    write_reg(REG_ANGULAR_GAIN, ag);
    write_reg(REG_STOP_RADIUS, {1'b0, sr});
    cfg_valid <= 1'b0;
  endtask

  // random pose, mostly near the goal so arrivals occur
  task automatic random_pose(logic signed [15:0] gx, logic signed [15:0] gy, int gap);
    logic signed [15:0] px, py;
    logic signed [14:0] hd;
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) begin
      px = 16'($urandom); py = 16'($urandom);
    end else begin
      px = gx + $signed(16'($urandom_range(0, 400)) - 16'sd200);
      py = gy + $signed(16'($urandom_range(0, 400)) - 16'sd200);
    end
    hd = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 25736) - 12868);
    send_pose(px, py, hd, gap);
  endtask

  initial begin
    logic signed [15:0] gx, gy;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero offset, extremes, each quadrant, heading extremes
    send_pose(16'sd5632, 16'sd5632, 15'sd0, 0);
    send_pose(16'sd5600, 16'sd5650, 15'sd12868, 0);
    send_pose(-16'sd32768, -16'sd32768, -15'sd12868, 0);
    send_pose(16'sd32767, 16'sd32767, 15'sd16383, 1);
    send_pose(16'sd32767, -16'sd32768, -15'sd16384, 0);
    send_pose(-16'sd32768, 16'sd32767, 15'sd0, 2);
    send_pose(16'sd5632, -16'sd100, 15'sd0, 0);
    send_pose(16'sd5632, 16'sd20000, 15'sd0, 0);
    send_pose(16'sd9000, 16'sd5632, 15'sd100, 0);
    send_pose(16'sd0, 16'sd5632, -15'sd100, 0);
    set_regs(16'h8000, 16'h7fff, 8'hff, 8'hff, 15'h7fff);
    send_pose(16'sd32767, -16'sd32768, 15'sd12868, 0);
    send_pose(-16'sd32768, 16'sd32767, -15'sd16384, 0);
    send_pose(16'sd0, 16'sd0, 15'sd16383, 0);
    set_regs(16'h7fff, 16'h8000, 8'h00, 8'h00, 15'h0000);
    send_pose(-16'sd32768, 16'sd32767, 15'sd0, 0);
    send_pose(16'sd32767, -16'sd32768, 15'sd0, 0);
    wait_drained();
    write_reg(reg_idx_t'(3'd7), 16'hffff);
    cfg_valid <= 1'b0;

    // random phases with varied settings
    for (int ph = 0; ph < 6; ph++) begin
      gx = 16'($urandom);
      gy = 16'($urandom);
      set_regs(gx, gy, 8'($urandom), 8'($urandom), 15'($urandom_range(0, 600)));
      steady_out = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if (n == 50) wait_drained();
        random_pose(gx, gy, (ph == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
      end
    end
    steady_out = 1'b0;

    wait_drained();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: go_to_goal_velocity_controller.f
design/gtg_pkg.sv
design/gtg_front.sv
design/gtg_queue.sv
design/gtg_back.sv
design/go_to_goal_velocity_controller.sv
dv/gtg_checker.sv
dv/tb_go_to_goal_velocity_controller.sv
